/* hw/rtl/bpa_pkg.sv */
`default_nettype none
package bpa_pkg;

  localparam int unsigned TopOrder = 10;
  localparam int unsigned Depth    = 1 << TopOrder;
  localparam int unsigned PageW    = TopOrder;
  localparam int unsigned CntW     = TopOrder + 1;
  localparam int unsigned OrdW     = 4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLR,
    CMD_LOAD,
    CMD_WALK_INIT,
    CMD_WALK_RD,
    CMD_WALK_STEP,
    CMD_PICK,
    CMD_SPLIT,
    CMD_TAKE,
    CMD_FREE_RD,
    CMD_UNMARK,
    CMD_MERGE_RD,
    CMD_MERGE,
    CMD_PLACE,
    CMD_FAIL_ALLOC,
    CMD_FAIL_FREE
  } cmd_e;

  // one word per page: head marks and block order
  typedef struct packed {
    logic            free;
    logic            used;
    logic [OrdW-1:0] ord;
  } entry_t;

  typedef struct packed {
    logic cfg_wr;
    logic clr_done;
    logic op_free;
    logic alloc_bad;
    logic walk_last;
    logic found;
    logic split_more;
    logic free_bad;
    logic merge_top;
    logic merge_ok;
  } stat_t;

  // smallest order whose block holds n pages
  function automatic logic [OrdW-1:0] order_for(input logic [CntW-1:0] n);
    logic [OrdW-1:0] k;
    k = '0;
    for (int i = 0; i < CntW; i++) begin
      if (((CntW+1)'(1) << i) < {1'b0, n}) k = OrdW'(i + 1);
    end
    return k;
  endfunction

  // order of the pool for a configured page count
  function automatic logic [OrdW-1:0] pool_order(input logic [CntW-1:0] pages);
    logic [CntW-1:0] n;
    logic [OrdW-1:0] k;
    n = pages;
    if (n == '0) n = CntW'(1);
    if (n > CntW'(Depth)) n = CntW'(Depth);
    k = '0;
    for (int i = 0; i <= TopOrder; i++) begin
      if ((CntW'(1) << i) <= n) k = OrdW'(i);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/bpa_req_if.sv */
`default_nettype none
interface bpa_req_if;
  import bpa_pkg::*;
  logic            valid;
  logic            ready;
  logic            opcode;
  logic [CntW-1:0] page_count;
  logic [PageW-1:0] block_index;
  modport source (output valid, opcode, page_count, block_index, input ready);
  modport sink (input valid, opcode, page_count, block_index, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bpa_rsp_if.sv */
`default_nettype none
interface bpa_rsp_if;
  import bpa_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [PageW-1:0] first_page;
  logic [CntW-1:0]  pages_free;
  modport source (output valid, status, first_page, pages_free, input ready);
  modport sink (input valid, status, first_page, pages_free, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bpa_cfg_if.sv */
`default_nettype none
interface bpa_cfg_if;
  import bpa_pkg::*;
  logic            valid;
  logic            ready;
  logic [CntW-1:0] pool_pages;
  modport source (output valid, pool_pages, input ready);
  modport sink (input valid, pool_pages, output ready);
endinterface
`default_nettype wire

/* hw/rtl/buddy_page_allocator.sv */
`default_nettype none
// Buddy page allocator over a pool of up to 1024 pages. After reset and after
// every write of pool_pages the block runs a clearing pass over its page
// table, during which no request is taken. An allocate walks the pool block
// by block from page 0 (one table read each), then splits the chosen block
// down to the wanted order; a free checks the block and then merges it with
// free buddies. Results leave through an output register, so a new request
// is taken while the last result waits.
module buddy_page_allocator (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpa_cfg_if.sink   cfg_i,
  bpa_req_if.sink   req_i,
  bpa_rsp_if.source rsp_o
);
  import bpa_pkg::*;

  stat_t stat;
  cmd_e  cmd, dp_cmd;
  logic  out_load;

  assign cfg_i.ready = 1'b1;
  // the output register loads on out_load, when the datapath sees CMD_NONE
  assign dp_cmd = out_load ? CMD_NONE : ((cmd == CMD_NONE) ? CMD_WALK_RD : cmd);

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .out_load_o  (out_load)
  );

  bpa_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .opcode_i      (req_i.opcode),
    .page_count_i  (req_i.page_count),
    .block_index_i (req_i.block_index),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_pages_i   (cfg_i.pool_pages),
    .stat_o        (stat),
    .status_o      (rsp_o.status),
    .first_page_o  (rsp_o.first_page),
    .pages_free_o  (rsp_o.pages_free)
  );

endmodule
`default_nettype wire

/* hw/rtl/bpa_dpath.sv */
`default_nettype none
module bpa_dpath (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire bpa_pkg::cmd_e            cmd_i,
  input  wire logic                     opcode_i,
  input  wire logic [bpa_pkg::CntW-1:0] page_count_i,
  input  wire logic [bpa_pkg::PageW-1:0] block_index_i,
  input  wire logic                     cfg_valid_i,
  input  wire logic [bpa_pkg::CntW-1:0] cfg_pages_i,
  output bpa_pkg::stat_t                stat_o,
  output logic [1:0]                    status_o,
  output logic [bpa_pkg::PageW-1:0]     first_page_o,
  output logic [bpa_pkg::CntW-1:0]      pages_free_o
);
  import bpa_pkg::*;

  entry_t mem [Depth];
  entry_t rdata_q;

  logic [CntW-1:0]  pool_pages_q, free_cnt_q, clr_q, walk_q, n_q;
  logic             op_q, best_vld_q;
  logic [PageW-1:0] base_q, a_q, best_adr_q, res_first_q;
  logic [OrdW-1:0]  want_q, k_q, o_q, best_ord_q;
  status_e          res_st_q;
  logic [1:0]       out_st_q;
  logic [PageW-1:0] out_first_q;
  logic [CntW-1:0]  out_free_q;

  logic [OrdW-1:0]  pool_ord, k_dec;
  logic [CntW-1:0]  pool_size, walk_nxt, want_pages;
  logic [PageW-1:0] buddy, waddr, raddr;
  logic             we, re, cand;
  entry_t           wdata;

  assign pool_ord   = pool_order(pool_pages_q);
  assign pool_size  = CntW'(1) << pool_ord;
  assign k_dec      = k_q - OrdW'(1);
  assign buddy      = a_q ^ (PageW'(1) << o_q);
  assign walk_nxt   = walk_q + (CntW'(1) << rdata_q.ord);
  assign want_pages = CntW'(1) << want_q;
  assign cand       = rdata_q.free && (rdata_q.ord >= want_q) &&
                      (!best_vld_q || (rdata_q.ord < best_ord_q));

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = a_q;
    raddr = walk_q[PageW-1:0];
    wdata = '0;
    unique case (cmd_i)
      CMD_CLR: begin
        we    = 1'b1;
        waddr = clr_q[PageW-1:0];
        if (clr_q == '0) wdata = '{free: 1'b1, used: 1'b0, ord: pool_ord};
      end
      CMD_WALK_RD: re = 1'b1;
      CMD_SPLIT: begin
        we    = 1'b1;
        waddr = a_q | (PageW'(1) << k_dec);
        wdata = '{free: 1'b1, used: 1'b0, ord: k_dec};
      end
      CMD_TAKE: begin
        we    = 1'b1;
        wdata = '{free: 1'b0, used: 1'b1, ord: want_q};
      end
      CMD_FREE_RD: begin
        re    = 1'b1;
        raddr = base_q;
      end
      CMD_UNMARK: begin
        we    = 1'b1;
        waddr = base_q;
      end
      CMD_MERGE_RD: begin
        re    = 1'b1;
        raddr = buddy;
      end
      CMD_MERGE: begin
        we    = 1'b1;
        waddr = buddy;
      end
      CMD_PLACE: begin
        we    = 1'b1;
        wdata = '{free: 1'b1, used: 1'b0, ord: o_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_pages_q <= CntW'(Depth);
      free_cnt_q   <= CntW'(Depth);
      clr_q        <= '0;
      best_vld_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pool_pages_q <= cfg_pages_i;
        clr_q        <= '0;
      end else if (cmd_i == CMD_CLR) begin
        clr_q <= clr_q + CntW'(1);
        if (clr_q == '0) free_cnt_q <= pool_size;
      end
      if (cmd_i == CMD_WALK_INIT) best_vld_q <= 1'b0;
      else if (cmd_i == CMD_WALK_STEP && cand) best_vld_q <= 1'b1;
      if (cmd_i == CMD_TAKE) free_cnt_q <= free_cnt_q - want_pages;
      if (cmd_i == CMD_PLACE) free_cnt_q <= free_cnt_q + want_pages;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q   <= opcode_i;
        n_q    <= page_count_i;
        base_q <= block_index_i;
        want_q <= order_for(page_count_i);
      end
      CMD_WALK_INIT: walk_q <= '0;
      CMD_WALK_STEP: begin
        walk_q <= walk_nxt;
        if (cand) begin
          best_ord_q <= rdata_q.ord;
          best_adr_q <= walk_q[PageW-1:0];
        end
      end
      CMD_PICK: begin
        a_q <= best_adr_q;
        k_q <= best_ord_q;
      end
      CMD_SPLIT: k_q <= k_dec;
      CMD_TAKE: begin
        res_st_q    <= ST_OK;
        res_first_q <= a_q;
      end
      CMD_UNMARK: begin
        a_q <= base_q;
        o_q <= rdata_q.ord;
      end
      CMD_MERGE: begin
        if (buddy < a_q) a_q <= buddy;
        o_q <= o_q + OrdW'(1);
      end
      CMD_PLACE: begin
        res_st_q    <= ST_OK;
        res_first_q <= '0;
      end
      CMD_FAIL_ALLOC: begin
        res_st_q    <= ST_NOSPACE;
        res_first_q <= '0;
      end
      CMD_FAIL_FREE: begin
        res_st_q    <= ST_BADFREE;
        res_first_q <= '0;
      end
      CMD_NONE: begin
        out_st_q    <= res_st_q;
        out_first_q <= res_first_q;
        out_free_q  <= free_cnt_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o            = '0;
    stat_o.cfg_wr     = cfg_valid_i;
    stat_o.clr_done   = (clr_q == CntW'(Depth - 1));
    stat_o.op_free    = op_q;
    stat_o.alloc_bad  = (n_q == '0) || (n_q > free_cnt_q) || (want_q > pool_ord);
    stat_o.walk_last  = (walk_nxt >= pool_size);
    stat_o.found      = best_vld_q;
    stat_o.split_more = (k_q > want_q);
    stat_o.free_bad   = (n_q == '0) || ({1'b0, base_q} >= pool_size) ||
                        !rdata_q.used || (rdata_q.ord != want_q);
    stat_o.merge_top  = (o_q == pool_ord);
    stat_o.merge_ok   = rdata_q.free && (rdata_q.ord == o_q);
  end

  assign status_o     = out_st_q;
  assign first_page_o = out_first_q;
  assign pages_free_o = out_free_q;

endmodule
`default_nettype wire

/* hw/rtl/bpa_ctrl.sv */
`default_nettype none
module bpa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bpa_pkg::stat_t stat_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bpa_pkg::cmd_e       cmd_o,
  output logic                out_load_o
);
  import bpa_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR     = 12'b0000_0000_0001,
    S_IDLE      = 12'b0000_0000_0010,
    S_DECODE    = 12'b0000_0000_0100,
    S_WALK_RD   = 12'b0000_0000_1000,
    S_WALK_CHK  = 12'b0000_0001_0000,
    S_PICK      = 12'b0000_0010_0000,
    S_SPLIT     = 12'b0000_0100_0000,
    S_FREE_RD   = 12'b0000_1000_0000,
    S_FREE_CHK  = 12'b0001_0000_0000,
    S_MERGE_RD  = 12'b0010_0000_0000,
    S_MERGE_CHK = 12'b0100_0000_0000,
    S_DONE      = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;

  assign in_ready_o  = (state_q == S_IDLE) && !stat_i.cfg_wr;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    out_load_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.op_free) begin
          state_d = S_FREE_RD;
        end else if (stat_i.alloc_bad) begin
          cmd_o   = CMD_FAIL_ALLOC;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_WALK_INIT;
          state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        cmd_o   = CMD_WALK_RD;
        state_d = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        cmd_o   = CMD_WALK_STEP;
        state_d = stat_i.walk_last ? S_PICK : S_WALK_RD;
      end
      S_PICK: begin
        if (stat_i.found) begin
          cmd_o   = CMD_PICK;
          state_d = S_SPLIT;
        end else begin
          cmd_o   = CMD_FAIL_ALLOC;
          state_d = S_DONE;
        end
      end
      S_SPLIT: begin
        if (stat_i.split_more) begin
          cmd_o = CMD_SPLIT;
        end else begin
          cmd_o   = CMD_TAKE;
          state_d = S_DONE;
        end
      end
      S_FREE_RD: begin
        cmd_o   = CMD_FREE_RD;
        state_d = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (stat_i.free_bad) begin
          cmd_o   = CMD_FAIL_FREE;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_UNMARK;
          state_d = S_MERGE_RD;
        end
      end
      S_MERGE_RD: begin
        if (stat_i.merge_top) begin
          cmd_o   = CMD_PLACE;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_MERGE_RD;
          state_d = S_MERGE_CHK;
        end
      end
      S_MERGE_CHK: begin
        if (stat_i.merge_ok) begin
          cmd_o   = CMD_MERGE;
          state_d = S_MERGE_RD;
        end else begin
          cmd_o   = CMD_PLACE;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // out_load_o in this state gives the datapath CMD_NONE, which loads the output register
        if (!out_valid_q || out_ready_i) begin
          out_load_o  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    if (stat_i.cfg_wr) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_DECODE)
    else $error("accepted beat not followed by decode");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside done state");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.cfg_wr |=> state_q == S_CLEAR)
    else $error("pool write did not start clearing pass");

endmodule
`default_nettype wire
